[src/glcm_histogram_accumulator_core_assert.svh]
// Assertion shorthands for the co-occurrence core.
`ifndef GLCM_HISTOGRAM_ACCUMULATOR_CORE_ASSERT_SVH
`define GLCM_HISTOGRAM_ACCUMULATOR_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clock, off while reset is high.
`define GLCM_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("glcm core: same-cycle check failed");

// Next-cycle implication.
`define GLCM_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("glcm core: next-cycle check failed");

`endif

[src/glcm_pkg.sv]
package glcm_pkg;

   localparam int BINS_DEF        = 64;
   localparam int TAPS_DEF        = 4;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int TAP_PORTS  = 4;
   localparam int SAMPLE_W   = 16;
   localparam int WEIGHT_W   = 16;
   localparam int GAIN_W     = 24;
   localparam int OFFSET_W   = 25;
   localparam int ACTIVE_W   = 7;
   localparam int SEL_W      = 6;
   localparam int COUNT_W    = 32;
   localparam int BIN_W_MAX  = 8;
   localparam int PRODUCT_W  = SAMPLE_W + WEIGHT_W;
   localparam int V_W        = PRODUCT_W + $clog2(TAP_PORTS);
   localparam int PROD_W     = V_W + GAIN_W;
   localparam int T_W        = PROD_W + 2;
   localparam int Q15_SHIFT  = 15;
   localparam int FRAC_SHIFT = 31;
   localparam int R_W        = T_W - FRAC_SHIFT;
   localparam logic [T_W-1:0] ROUND_HALF = T_W'(64'h4000_0000);
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(32768);

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_BINS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TAP_WEIGHT_A = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TAP_WEIGHT_B = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TAP_WEIGHT_C = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TAP_WEIGHT_D = 3'd6;

   localparam logic [ACTIVE_W-1:0] ACTIVE_BINS_RST = 7'd64;
   localparam logic [GAIN_W-1:0]   GAIN_RST        = 24'd65536;
   localparam logic [WEIGHT_W-1:0] WEIGHT_A_RST    = 16'd32768;

   localparam logic [1:0] OP_ACCUMULATE = 2'd0;
   localparam logic [1:0] OP_READ       = 2'd1;
   localparam logic [1:0] OP_CLEAR      = 2'd2;

   typedef enum logic [1:0] {
      SOP_BUMP  = 2'd0,
      SOP_READ  = 2'd1,
      SOP_CLEAR = 2'd2
   } glcm_store_op_type;

   typedef struct packed {
      logic              start;
      glcm_store_op_type op;
      logic              diag;
   } glcm_store_cmd_type;

   typedef struct packed {
      logic ready;
      logic idle;
      logic done;
   } glcm_store_stat_type;

   typedef struct packed {
      logic [1:0]          opcode;
      logic [SAMPLE_W-1:0] ref_sample;
      logic [SAMPLE_W-1:0] tap_a;
      logic [SAMPLE_W-1:0] tap_b;
      logic [SAMPLE_W-1:0] tap_c;
      logic [SAMPLE_W-1:0] tap_d;
      logic                taps_valid;
      logic [SEL_W-1:0]    sel_row;
      logic [SEL_W-1:0]    sel_col;
   } glcm_req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] bin_count;
      logic [SEL_W-1:0]   ref_bin;
      logic [SEL_W-1:0]   nbr_bin;
      logic               counted;
   } glcm_rsp_type;

endpackage

[src/glcm_tap_lane.sv]
module glcm_tap_lane #(
   parameter int SAMPLE_BITS = glcm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic [glcm_pkg::SAMPLE_W-1:0]   sample,
   input  logic [glcm_pkg::WEIGHT_W-1:0]   weight,
   output logic [glcm_pkg::PRODUCT_W-1:0]  product
);
   import glcm_pkg::*;

   localparam int SB = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

   logic [SB-1:0]        sample_used;
   logic [PRODUCT_W-1:0] product_in;
   logic [PRODUCT_W-1:0] product_ff;

   assign sample_used = sample[SB-1:0];
   assign product_in  = PRODUCT_W'(sample_used) * PRODUCT_W'(weight);
   assign product     = product_ff;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

[src/glcm_lane_merge.sv]
module glcm_lane_merge #(
   parameter int LANES = glcm_pkg::TAPS_DEF
) (
   input  logic                           clock,
   input  logic [glcm_pkg::PRODUCT_W-1:0] products [LANES],
   output logic [glcm_pkg::V_W-1:0]       sum
);
   import glcm_pkg::*;

   logic [V_W-1:0] sum_in;
   logic [V_W-1:0] sum_ff;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < LANES; i++) begin
         sum_in = sum_in + V_W'(products[i]);
      end
   end

   assign sum = sum_ff;

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

endmodule

[src/glcm_quantizer.sv]
module glcm_quantizer #(
   parameter int BINS = glcm_pkg::BINS_DEF
) (
   input  logic                                clock,
   input  logic [glcm_pkg::V_W-1:0]            value,
   input  logic [glcm_pkg::GAIN_W-1:0]         gain,
   input  logic signed [glcm_pkg::OFFSET_W-1:0] offset,
   input  logic [$clog2(BINS)-1:0]             top_bin,
   output logic [$clog2(BINS)-1:0]             bin
);
   import glcm_pkg::*;

   localparam int BIN_W = $clog2(BINS);

   logic [PROD_W-1:0]    prod_in;
   logic [PROD_W-1:0]    prod_ff;
   logic signed [T_W-1:0] off_ext;
   logic signed [T_W-1:0] t_val;
   logic [T_W-1:0]       t_round;
   logic [R_W-1:0]       r_val;
   logic [BIN_W-1:0]     bin_in;
   logic [BIN_W-1:0]     bin_ff;

   assign prod_in = PROD_W'(value) * PROD_W'(gain);

   // t = v*gain - offset*2^15, round half up at 2^31, clamp to [0, top]
   always_comb begin
      off_ext = {{(T_W-OFFSET_W){offset[OFFSET_W-1]}}, offset} <<< Q15_SHIFT;
      t_val   = $signed({2'b00, prod_ff}) - off_ext;
      t_round = t_val + ROUND_HALF;
      r_val   = t_round[T_W-1:FRAC_SHIFT];
      if (t_val[T_W-1]) begin
         bin_in = '0;
      end else if (r_val > R_W'(top_bin)) begin
         bin_in = top_bin;
      end else begin
         bin_in = r_val[BIN_W-1:0];
      end
   end

   assign bin = bin_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      bin_ff  <= bin_in;
   end

endmodule

[src/glcm_bin_store.sv]
module glcm_bin_store #(
   parameter int BINS = glcm_pkg::BINS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  glcm_pkg::glcm_store_cmd_type       cmd,
   input  logic [$clog2(BINS*BINS)-1:0]       addr_a,
   input  logic [$clog2(BINS*BINS)-1:0]       addr_b,
   output glcm_pkg::glcm_store_stat_type      stat,
   output logic [glcm_pkg::COUNT_W-1:0]       rdata
);
   import glcm_pkg::*;

   localparam int DEPTH  = BINS * BINS;
   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic [4:0] {
      SS_INIT = 5'b00001,
      SS_IDLE = 5'b00010,
      SS_RDA  = 5'b00100,
      SS_WRA  = 5'b01000,
      SS_WRB  = 5'b10000
   } glcm_store_state_type;

   logic [COUNT_W-1:0] store_mem [DEPTH];

   glcm_store_state_type state_in, state_ff;
   logic [ADDR_W-1:0]    cnt_in, cnt_ff;
   glcm_store_op_type    op_in, op_ff;
   logic                 diag_in, diag_ff;
   logic [ADDR_W-1:0]    a_in, a_ff;
   logic [ADDR_W-1:0]    b_in, b_ff;
   logic                 done_in, done_ff;
   logic [COUNT_W-1:0]   rdata_ff;

   logic               we;
   logic [ADDR_W-1:0]  waddr;
   logic [COUNT_W-1:0] wdata;
   logic               re;
   logic [ADDR_W-1:0]  raddr;
   logic [1:0]         inc;
   logic [COUNT_W:0]   sum_wide;
   logic [COUNT_W-1:0] sat_count;

   // saturating increment; a diagonal bin takes two at once
   always_comb begin
      sum_wide  = {1'b0, rdata_ff} + (COUNT_W+1)'(inc);
      sat_count = sum_wide[COUNT_W] ? '1 : sum_wide[COUNT_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      diag_in  = diag_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      done_in  = 1'b0;
      we       = 1'b0;
      waddr    = a_ff;
      wdata    = '0;
      re       = 1'b0;
      raddr    = a_ff;
      inc      = 2'd1;
      case (state_ff)
         SS_INIT: begin
            we     = 1'b1;
            waddr  = cnt_ff;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = SS_IDLE;
            end
         end
         SS_IDLE: begin
            if (cmd.start) begin
               op_in    = cmd.op;
               diag_in  = cmd.diag;
               a_in     = addr_a;
               b_in     = addr_b;
               state_in = SS_RDA;
            end
         end
         SS_RDA: begin
            case (op_ff)
               SOP_BUMP: begin
                  re       = 1'b1;
                  state_in = SS_WRA;
               end
               SOP_READ: begin
                  re       = 1'b1;
                  done_in  = 1'b1;
                  state_in = SS_IDLE;
               end
               SOP_CLEAR: begin
                  we       = 1'b1;
                  done_in  = 1'b1;
                  state_in = SS_IDLE;
               end
               default: begin
                  done_in  = 1'b1;
                  state_in = SS_IDLE;
               end
            endcase
         end
         SS_WRA: begin
            inc   = diag_ff ? 2'd2 : 2'd1;
            we    = 1'b1;
            wdata = sat_count;
            if (diag_ff) begin
               done_in  = 1'b1;
               state_in = SS_IDLE;
            end else begin
               re       = 1'b1;
               raddr    = b_ff;
               state_in = SS_WRB;
            end
         end
         SS_WRB: begin
            we       = 1'b1;
            waddr    = b_ff;
            wdata    = sat_count;
            done_in  = 1'b1;
            state_in = SS_IDLE;
         end
         default: begin
            state_in = SS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         store_mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= store_mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SS_INIT;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      diag_ff <= diag_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
   end

   assign stat.ready = (state_ff != SS_INIT);
   assign stat.idle  = (state_ff == SS_IDLE);
   assign stat.done  = done_ff;
   assign rdata      = rdata_ff;

endmodule

[src/glcm_histogram_accumulator_core.sv]
// Symmetric grey-level co-occurrence accumulator.
// req channel (req_valid/req_stall/req_data): one transaction per pixel or bin
//   command; opcode 0 accumulates, 1 reads a bin, 2 clears a bin.
// rsp channel (rsp_valid/rsp_stall/rsp_data): exactly one transaction per
//   request, in request order.
// Register port (psel/penable/pwrite/paddr/pwdata/prdata/pready): seven
//   32-bit registers at 4*i, written only while the core is idle: a duty of
//   the user that the core itself leaves unchecked.
// One request is in flight at a time. The sequencer steps each accumulated
//   pixel through the tap multiplier lanes, the lane merge, the two-stage
//   quantiser and the read-modify-write of both symmetric bins in the count
//   memory (one bin on the diagonal); a read or clear goes straight to the
//   count memory, and a skipped or unknown request straight to the result.
//   The next request is taken in the cycle after the result is registered.
// After reset a clearing pass zeroes all BINS*BINS count memory entries
//   (4096 by default); req_stall stays high until it finishes. Registers
//   return to their reset values at once and accept writes during the pass.
// A stalled result holds in the output register; one further request may be
//   accepted and processed, then the core waits for the output to drain.
module glcm_histogram_accumulator_core #(
   parameter int BINS        = glcm_pkg::BINS_DEF,
   parameter int TAPS        = glcm_pkg::TAPS_DEF,
   parameter int SAMPLE_BITS = glcm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  glcm_pkg::glcm_req_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output glcm_pkg::glcm_rsp_type             rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [glcm_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [glcm_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [glcm_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);
   import glcm_pkg::*;

`include "glcm_histogram_accumulator_core_assert.svh"

   localparam int BIN_W  = $clog2(BINS);
   localparam int ADDR_W = $clog2(BINS * BINS);
   localparam int LANES  = (TAPS < TAP_PORTS) ? TAPS : TAP_PORTS;

   typedef enum logic [8:0] {
      ST_INIT  = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_LANE  = 9'b000000100,
      ST_MERGE = 9'b000001000,
      ST_QMUL  = 9'b000010000,
      ST_QFIN  = 9'b000100000,
      ST_STORE = 9'b001000000,
      ST_WAIT  = 9'b010000000,
      ST_DONE  = 9'b100000000
   } glcm_state_type;

   glcm_state_type state_in, state_ff;
   glcm_req_type   item_in, item_ff;
   glcm_rsp_type   rsp_data_in, rsp_data_ff;
   glcm_rsp_type   rsp_next;
   logic           rsp_valid_in, rsp_valid_ff;

   logic [ACTIVE_W-1:0]  active_bins_in, active_bins_ff;
   logic [GAIN_W-1:0]    gain_in, gain_ff;
   logic signed [OFFSET_W-1:0] offset_in, offset_ff;
   logic [WEIGHT_W-1:0]  weight_in [TAP_PORTS];
   logic [WEIGHT_W-1:0]  weight_ff [TAP_PORTS];

   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_idx;

   logic                 accept;
   logic                 rsp_free;
   logic                 load_rsp;
   logic                 acc_ok;
   logic                 rd_ok;

   logic [SAMPLE_W-1:0]  tap_arr [TAP_PORTS];
   logic [PRODUCT_W-1:0] lane_prod [LANES];
   logic [PRODUCT_W-1:0] ref_prod;
   logic [V_W-1:0]       nbr_v;
   logic [V_W-1:0]       ref_v;
   logic [8:0]           top_wide;
   logic [BIN_W-1:0]     top_bin;
   logic [BIN_W-1:0]     ref_bin;
   logic [BIN_W-1:0]     nbr_bin;
   logic [BIN_W_MAX-1:0] ref_bin8;
   logic [BIN_W_MAX-1:0] nbr_bin8;

   glcm_store_cmd_type   store_cmd;
   glcm_store_stat_type  store_stat;
   logic [ADDR_W-1:0]    store_addr_a;
   logic [ADDR_W-1:0]    store_addr_b;
   logic [COUNT_W-1:0]   store_rdata;

   function automatic logic sel_ok(glcm_req_type r);
      return (32'(r.sel_row) < BINS) && (32'(r.sel_col) < BINS);
   endfunction

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_idx   = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      active_bins_in = active_bins_ff;
      gain_in        = gain_ff;
      offset_in      = offset_ff;
      for (int i = 0; i < TAP_PORTS; i++) begin
         weight_in[i] = weight_ff[i];
      end
      if (csr_write) begin
         case (csr_idx)
            REG_ACTIVE_BINS:  active_bins_in = pwdata[ACTIVE_W-1:0];
            REG_GAIN:         gain_in        = pwdata[GAIN_W-1:0];
            REG_OFFSET:       offset_in      = $signed(pwdata[OFFSET_W-1:0]);
            REG_TAP_WEIGHT_A: weight_in[0]   = pwdata[WEIGHT_W-1:0];
            REG_TAP_WEIGHT_B: weight_in[1]   = pwdata[WEIGHT_W-1:0];
            REG_TAP_WEIGHT_C: weight_in[2]   = pwdata[WEIGHT_W-1:0];
            REG_TAP_WEIGHT_D: weight_in[3]   = pwdata[WEIGHT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_ACTIVE_BINS:  prdata = CSR_DATA_W'(active_bins_ff);
         REG_GAIN:         prdata = CSR_DATA_W'(gain_ff);
         REG_OFFSET:       prdata = CSR_DATA_W'($unsigned(offset_ff));
         REG_TAP_WEIGHT_A: prdata = CSR_DATA_W'(weight_ff[0]);
         REG_TAP_WEIGHT_B: prdata = CSR_DATA_W'(weight_ff[1]);
         REG_TAP_WEIGHT_C: prdata = CSR_DATA_W'(weight_ff[2]);
         REG_TAP_WEIGHT_D: prdata = CSR_DATA_W'(weight_ff[3]);
         default:          prdata = '0;
      endcase
   end

   // top active bin: above BINS acts as BINS, zero and one give bin 0
   always_comb begin
      if (32'(active_bins_ff) > BINS) begin
         top_wide = 9'(BINS - 1);
      end else if (active_bins_ff == '0) begin
         top_wide = '0;
      end else begin
         top_wide = 9'(active_bins_ff) - 9'd1;
      end
      top_bin = top_wide[BIN_W-1:0];
   end

   // datapath lanes
   assign tap_arr[0] = item_ff.tap_a;
   assign tap_arr[1] = item_ff.tap_b;
   assign tap_arr[2] = item_ff.tap_c;
   assign tap_arr[3] = item_ff.tap_d;

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      glcm_tap_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
         .clock   (clock),
         .sample  (tap_arr[g]),
         .weight  (weight_ff[g]),
         .product (lane_prod[g])
      );
   end

   glcm_tap_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_ref_lane (
      .clock   (clock),
      .sample  (item_ff.ref_sample),
      .weight  (WEIGHT_ONE),
      .product (ref_prod)
   );

   glcm_lane_merge #(.LANES(LANES)) u_merge (
      .clock    (clock),
      .products (lane_prod),
      .sum      (nbr_v)
   );

   assign ref_v = V_W'(ref_prod);

   glcm_quantizer #(.BINS(BINS)) u_ref_quant (
      .clock   (clock),
      .value   (ref_v),
      .gain    (gain_ff),
      .offset  (offset_ff),
      .top_bin (top_bin),
      .bin     (ref_bin)
   );

   glcm_quantizer #(.BINS(BINS)) u_nbr_quant (
      .clock   (clock),
      .value   (nbr_v),
      .gain    (gain_ff),
      .offset  (offset_ff),
      .top_bin (top_bin),
      .bin     (nbr_bin)
   );

   // count memory
   always_comb begin
      store_cmd.start = (state_ff == ST_STORE);
      store_cmd.diag  = (ref_bin == nbr_bin);
      case (item_ff.opcode)
         OP_ACCUMULATE: store_cmd.op = SOP_BUMP;
         OP_READ:       store_cmd.op = SOP_READ;
         default:       store_cmd.op = SOP_CLEAR;
      endcase
      if (item_ff.opcode == OP_ACCUMULATE) begin
         store_addr_a = ADDR_W'(32'(nbr_bin) * BINS + 32'(ref_bin));
         store_addr_b = ADDR_W'(32'(ref_bin) * BINS + 32'(nbr_bin));
      end else begin
         store_addr_a = ADDR_W'(32'(item_ff.sel_row) * BINS + 32'(item_ff.sel_col));
         store_addr_b = store_addr_a;
      end
   end

   glcm_bin_store #(.BINS(BINS)) u_store (
      .clock  (clock),
      .reset  (reset),
      .cmd    (store_cmd),
      .addr_a (store_addr_a),
      .addr_b (store_addr_b),
      .stat   (store_stat),
      .rdata  (store_rdata)
   );

   // sequencer
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign load_rsp  = (state_ff == ST_DONE) && rsp_free;
   assign item_in   = accept ? req_data : item_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (store_stat.ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_data.opcode == OP_ACCUMULATE && req_data.taps_valid) begin
                  state_in = ST_LANE;
               end else if ((req_data.opcode == OP_READ || req_data.opcode == OP_CLEAR)
                            && sel_ok(req_data)) begin
                  state_in = ST_STORE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_LANE:  state_in = ST_MERGE;
         ST_MERGE: state_in = ST_QMUL;
         ST_QMUL:  state_in = ST_QFIN;
         ST_QFIN:  state_in = ST_STORE;
         ST_STORE: state_in = ST_WAIT;
         ST_WAIT: begin
            if (store_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   // result
   assign acc_ok   = (item_ff.opcode == OP_ACCUMULATE) && item_ff.taps_valid;
   assign rd_ok    = (item_ff.opcode == OP_READ) && sel_ok(item_ff);
   assign ref_bin8 = BIN_W_MAX'(ref_bin);
   assign nbr_bin8 = BIN_W_MAX'(nbr_bin);

   always_comb begin
      rsp_next = '0;
      if (acc_ok) begin
         rsp_next.ref_bin = ref_bin8[SEL_W-1:0];
         rsp_next.nbr_bin = nbr_bin8[SEL_W-1:0];
         rsp_next.counted = 1'b1;
      end
      if (rd_ok) begin
         rsp_next.bin_count = store_rdata;
      end
   end

   assign rsp_data_in  = load_rsp ? rsp_next : rsp_data_ff;
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT;
         rsp_valid_ff   <= 1'b0;
         active_bins_ff <= ACTIVE_BINS_RST;
         gain_ff        <= GAIN_RST;
         offset_ff      <= '0;
         weight_ff[0]   <= WEIGHT_A_RST;
         for (int i = 1; i < TAP_PORTS; i++) begin
            weight_ff[i] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         active_bins_ff <= active_bins_in;
         gain_ff        <= gain_in;
         offset_ff      <= offset_in;
         for (int i = 0; i < TAP_PORTS; i++) begin
            weight_ff[i] <= weight_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   `GLCM_ASSERT_IMPL(a_start_when_store_idle, store_cmd.start, store_stat.idle)
   `GLCM_ASSERT_IMPL(a_done_only_in_wait, store_stat.done, state_ff == ST_WAIT)
   `GLCM_ASSERT_IMPL(a_no_accept_while_clearing, !store_stat.ready, req_stall)
   `GLCM_ASSERT_IMPL(a_counted_has_no_count, rsp_valid_ff && rsp_data_ff.counted, rsp_data_ff.bin_count == '0)
   `GLCM_ASSERT_NEXT(a_done_loads_result, load_rsp, rsp_valid_ff && state_ff == ST_IDLE)

endmodule
